FILE: rtl/rrcm_pkg.sv
// Shared types and constants for the rounded rectangle coverage mask.
package rrcm_pkg;

   localparam int MAX_DIM_DEF  = 4096;
   localparam int COORD_W      = 13;
   localparam int LEN_W        = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int ROOT_W       = 40;
   localparam int ROOT_STEPS   = 20;
   localparam int STEPS_PER_ST = 2;
   localparam int ROOT_STAGES  = ROOT_STEPS / STEPS_PER_ST;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND   = 3'd4;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] res;
   } root_type;

   typedef struct packed {
      logic               bad;
      logic signed [20:0] e;
   } side_type;

endpackage

FILE: rtl/rounded_rect_coverage_mask.sv
// Rounded rectangle coverage mask: one coordinate per clock, 14-stage pipeline.
// Each accepted pixel transfer is offered as one alpha byte on rsp after it
// has passed all stages; with rsp_tready high the block takes one pixel every cycle.
// The pipeline is the square root, resolved two result bits per stage over ten
// stages, plus the distance, squaring, sum and coverage stages. Stages advance
// independently, so bubbles collapse under backpressure. Write registers only
// when idle.
module rounded_rect_coverage_mask #(
   parameter int MAX_DIM = rrcm_pkg::MAX_DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rrcm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rrcm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // pixel_x, pixel_y
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata   // alpha, size_bad
);
   import rrcm_pkg::*;

   localparam int NST = ROOT_STAGES + 4;
   localparam int OST = NST - 1;

   logic                mode_ff;
   logic [COORD_W-1:0]  width_ff, height_ff;
   logic [LEN_W-1:0]    radius_ff, band_ff;

   logic [NST-1:0]      v_ff;
   logic [NST:0]        rdy;
   side_type            side_ff [NST-1];
   logic [17:0]         ax_ff, ay_ff;
   logic [35:0]         ax2_ff, ay2_ff;
   root_type            root_ff [ROOT_STAGES+1];
   root_type            root_nx [ROOT_STAGES];
   logic [7:0]          alpha_ff;
   logic                bad_ff;
   logic [7:0]          alpha_nx;

   logic signed [17:0]  hx, hy, m, rad, bnd;
   logic signed [20:0]  px, py, apx, apy, qx, qy, mx;
   logic                bad;
   side_type            side0;

   function automatic logic [4:0] clamp16(input logic signed [21:0] v);
      logic [4:0] r;
      if (v < 0) r = 5'd0;
      else if (v > 22'sd16) r = 5'd16;
      else r = v[4:0];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         radius_ff <= '0;
         band_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= csr_wdata[0];
            CSR_WIDTH:  width_ff  <= csr_wdata[COORD_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[COORD_W-1:0];
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_BAND:   band_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // config-derived terms
   always_comb begin
      hx  = $signed({2'b0, width_ff, 3'b0}) - 18'sd16;
      hy  = $signed({2'b0, height_ff, 3'b0}) - 18'sd16;
      m   = (hx < hy) ? hx : hy;
      rad = ($signed({2'b0, radius_ff}) > m) ? m : $signed({2'b0, radius_ff});
      bnd = ($signed({2'b0, band_ff}) > m) ? m : $signed({2'b0, band_ff});
      bad = (width_ff == '0) || (height_ff == '0)
         || ({1'b0, width_ff} > 14'(MAX_DIM)) || ({1'b0, height_ff} > 14'(MAX_DIM));
   end

   // handshake chain
   always_comb begin
      rdy[NST] = rsp_tready;
      for (int k = NST - 1; k >= 0; k--) rdy[k] = !v_ff[k] || rdy[k+1];
   end
   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= req_tvalid;
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // stage 0: folded box distance
   always_comb begin
      px  = $signed({4'b0, req_tdata[12:0], 4'b0}) + 21'sd8
          - $signed({5'b0, width_ff, 3'b0});
      py  = $signed({4'b0, req_tdata[25:13], 4'b0}) + 21'sd8
          - $signed({5'b0, height_ff, 3'b0});
      apx = px[20] ? -px : px;
      apy = py[20] ? -py : py;
      qx  = apx - 21'(hx) + 21'(rad);
      qy  = apy - 21'(hy) + 21'(rad);
      mx  = (qx > qy) ? qx : qy;
      if (mx > 0) mx = '0;
      side0.bad = bad;
      side0.e   = mx - 21'(rad);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         ax_ff      <= qx[20] ? '0 : qx[17:0];
         ay_ff      <= qy[20] ? '0 : qy[17:0];
         side_ff[0] <= side0;
      end
      if (rdy[1]) begin
         ax2_ff <= ax_ff * ax_ff;
         ay2_ff <= ay_ff * ay_ff;
      end
      if (rdy[2]) begin
         root_ff[0].rem <= {1'b0, ({1'b0, ax2_ff} + {1'b0, ay2_ff}), 2'b0};
         root_ff[0].res <= '0;
      end
      for (int k = 0; k < ROOT_STAGES; k++) begin
         if (rdy[3+k]) root_ff[k+1] <= root_nx[k];
      end
      for (int k = 1; k < NST - 1; k++) begin
         if (rdy[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_root
      rrcm_sqrt_stage #(.FIRST(i * STEPS_PER_ST)) u_step (
         .d_in  (root_ff[i]),
         .d_out (root_nx[i])
      );
   end

   // output stage: signed distance to coverage
   always_comb begin
      logic [19:0]        outside;
      logic signed [21:0] t, ti;
      logic [4:0]         outer, inner, cov;
      logic [12:0]        scaled;
      outside = 20'((root_ff[ROOT_STAGES].res[19:0] + 21'd1) >> 1);
      t       = 22'sd8 - ($signed({2'b0, outside}) + 22'(side_ff[OST-1].e));
      ti      = t - 22'(bnd);
      outer   = clamp16(t);
      inner   = clamp16(ti);
      if (!mode_ff) cov = outer;
      else cov = (outer > inner) ? outer - inner : 5'd0;
      scaled  = {8'b0, cov} * 13'd255 + 13'd8;
      alpha_nx = side_ff[OST-1].bad ? 8'd0 : scaled[11:4];
   end

   always_ff @(posedge clock) begin
      if (rdy[OST]) begin
         alpha_ff <= alpha_nx;
         bad_ff   <= side_ff[OST-1].bad;
      end
   end

   assign rsp_tvalid = v_ff[OST];
   assign rsp_tdata  = {7'b0, bad_ff, alpha_ff};
endmodule

FILE: rtl/rrcm_sqrt_stage.sv
// Two digit steps of the bitwise integer square root.
module rrcm_sqrt_stage #(
   parameter int FIRST = 0
) (
   input  rrcm_pkg::root_type d_in,
   output rrcm_pkg::root_type d_out
);
   import rrcm_pkg::*;

   always_comb begin
      root_type          r;
      logic [ROOT_W-1:0] bitv;
      logic [ROOT_W-1:0] trial;
      r = d_in;
      for (int j = 0; j < STEPS_PER_ST; j++) begin
         bitv  = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - (FIRST + j)));
         trial = r.res + bitv;
         if (r.rem >= trial) begin
            r.rem = r.rem - trial;
            r.res = (r.res >> 1) + bitv;
         end else begin
            r.res = r.res >> 1;
         end
      end
      d_out = r;
   end
endmodule

FILE: rtl/rrcm_checker.sv
// Port-level checks for the rounded rectangle coverage mask.
module rrcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp dropped");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("rsp changed");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0) else $error("bad size alpha");
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("stalled with empty output");
endmodule

bind rounded_rect_coverage_mask rrcm_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
